@@ rtl/ccr_pkg.sv @@
// Package for the clock counter replacement block: sizes, codes and the
// structs passed between the sequencer, the counter unit and the memory.
// Depends on nothing; every other file uses it.
package ccr_pkg;

  localparam int SLOTS      = 1024;
  localparam int COUNT_BITS = 8;

  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int FILL_BITS = $clog2(SLOTS + 1);
  localparam int IDX_W     = 10;

  localparam logic MODE_HIT = 1'b0;
  localparam logic MODE_REQ = 1'b1;

  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIT,
    ST_SWEEP,
    ST_DONE
  } state_e;

  typedef enum logic {
    ALU_INC,
    ALU_DEC
  } alu_op_e;

  typedef struct packed {
    alu_op_e op;
    count_t  value;
  } alu_req_t;

  typedef struct packed {
    count_t value;
    logic   zero;
  } alu_rsp_t;

  typedef struct packed {
    logic   we;
    slot_t  waddr;
    count_t wdata;
    slot_t  raddr;
  } mem_req_t;

endpackage

@@ rtl/ccr_if.sv @@
// Valid/ready channel interfaces for the clock counter replacement block.
// Depends on ccr_pkg for the payload widths.
interface ccr_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [ccr_pkg::IDX_W-1:0] slot_index;

  modport source (output valid, output mode, output slot_index, input ready);
  modport sink   (input valid, input mode, input slot_index, output ready);
endinterface

interface ccr_out_if;
  logic                      valid;
  logic                      ready;
  logic [ccr_pkg::IDX_W-1:0] chosen_slot;
  logic                      was_free;

  modport source (output valid, output chosen_slot, output was_free, input ready);
  modport sink   (input valid, input chosen_slot, input was_free, output ready);
endinterface

@@ rtl/ccr_alu.sv @@
// Shared counter unit: saturating increment for hits, decrement and zero
// test for the clock sweep. Depends on ccr_pkg.
module ccr_alu (
  input  ccr_pkg::alu_req_t req_i,
  output ccr_pkg::alu_rsp_t rsp_o
);
  import ccr_pkg::*;

  always_comb begin
    rsp_o.zero  = (req_i.value == '0);
    rsp_o.value = req_i.value;
    unique case (req_i.op)
      ALU_INC: begin
        if (req_i.value != '1) begin
          rsp_o.value = req_i.value + COUNT_BITS'(1);
        end
      end
      ALU_DEC: begin
        rsp_o.value = req_i.value - COUNT_BITS'(1);
      end
      default: rsp_o.value = req_i.value;
    endcase
  end

endmodule

@@ rtl/ccr_mem.sv @@
// Usage counter memory: one write port and one read port, read data
// registered. Depends on ccr_pkg.
module ccr_mem (
  input  logic              clk_i,
  input  ccr_pkg::mem_req_t req_i,
  output ccr_pkg::count_t   rdata_o
);
  import ccr_pkg::*;

  count_t mem [SLOTS];
  count_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ccr_seq.sv @@
// Sequencer: clears the counters, runs hits, free-slot grants and victim
// sweeps, keeps the hand, fill count and output register. Uses ccr_pkg.
module ccr_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      in_mode_i,
  input  logic [ccr_pkg::IDX_W-1:0] in_slot_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ccr_pkg::IDX_W-1:0] out_slot_o,
  output logic                      out_free_o,
  output ccr_pkg::mem_req_t         mem_req_o,
  input  ccr_pkg::count_t           mem_rdata_i,
  output ccr_pkg::alu_req_t         alu_req_o,
  input  ccr_pkg::alu_rsp_t         alu_rsp_i
);
  import ccr_pkg::*;

  localparam slot_t LAST_SLOT = SLOT_BITS'(SLOTS - 1);

  state_e                 state_q, state_d;
  slot_t                  hand_q, hand_d;
  logic [FILL_BITS-1:0]   fill_q, fill_d;
  slot_t                  addr_q, addr_d;
  logic [IDX_W-1:0]       res_slot_q, res_slot_d;
  logic                   res_free_q, res_free_d;
  logic                   out_valid_q, out_valid_d;
  logic [IDX_W-1:0]       out_slot_q, out_slot_d;
  logic                   out_free_q, out_free_d;
  slot_t                  hand_next;

  assign hand_next = (hand_q == LAST_SLOT) ? '0 : hand_q + SLOT_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      hand_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hand_q      <= hand_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    res_slot_q <= res_slot_d;
    res_free_q <= res_free_d;
    out_slot_q <= out_slot_d;
    out_free_q <= out_free_d;
  end

  always_comb begin
    state_d     = state_q;
    hand_d      = hand_q;
    fill_d      = fill_q;
    addr_d      = addr_q;
    res_slot_d  = res_slot_q;
    res_free_d  = res_free_q;
    out_valid_d = out_valid_q;
    out_slot_d  = out_slot_q;
    out_free_d  = out_free_q;
    in_ready_o  = 1'b0;
    mem_req_o   = '{we: 1'b0, waddr: hand_q, wdata: alu_rsp_i.value, raddr: hand_q};
    alu_req_o   = '{op: ALU_DEC, value: mem_rdata_i};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        // The hand doubles as the clear address and wraps back to zero.
        mem_req_o.we    = 1'b1;
        mem_req_o.wdata = '0;
        hand_d          = hand_next;
        if (hand_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i == MODE_HIT) begin
            if (32'(in_slot_i) < SLOTS) begin
              mem_req_o.raddr = SLOT_BITS'(in_slot_i);
              addr_d          = SLOT_BITS'(in_slot_i);
              state_d         = ST_HIT;
            end
          end else if (fill_q < FILL_BITS'(SLOTS)) begin
            res_slot_d = IDX_W'(fill_q);
            res_free_d = 1'b1;
            fill_d     = fill_q + FILL_BITS'(1);
            state_d    = ST_DONE;
          end else begin
            mem_req_o.raddr = hand_q;
            state_d         = ST_SWEEP;
          end
        end
      end
      ST_HIT: begin
        alu_req_o.op    = ALU_INC;
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = addr_q;
        state_d         = ST_IDLE;
      end
      ST_SWEEP: begin
        hand_d = hand_next;
        if (alu_rsp_i.zero) begin
          res_slot_d = IDX_W'(hand_q);
          res_free_d = 1'b0;
          state_d    = ST_DONE;
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.raddr = hand_next;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_slot_d  = res_slot_q;
          out_free_d  = res_free_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_slot_o  = out_slot_q;
  assign out_free_o  = out_free_q;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_BITS'(SLOTS))
    else $error("fill count passed the slot count");

  a_sweep_write_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && mem_req_o.we) |-> !alu_rsp_i.zero)
    else $error("sweep decremented a counter at zero");

  a_hand_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |=> (hand_q == (($past(hand_q) == LAST_SLOT) ? '0
                                          : $past(hand_q) + SLOT_BITS'(1))))
    else $error("hand did not advance by one slot in the sweep");

  a_free_only_while_filling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (fill_q == FILL_BITS'(SLOTS)))
    else $error("sweep started before all slots were handed out");
`endif

endmodule

@@ rtl/clock_counter_replacement.sv @@
// A hit writes back the saturating increment of its slot's counter; a request from
// never-used slots goes to the output register; an eviction sweeps the hand with one
// counter read-modify-write per cycle through a dual-port counter memory.
// Throughput: one transaction at a time; ready is high only while the sequencer is idle.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes all SLOTS (1024)
// counters, and no input transaction is taken until it ends.
module clock_counter_replacement (
  input logic            clk_i,
  input logic            rst_ni,
  ccr_in_if.sink         in_i,
  ccr_out_if.source      out_o
);
  import ccr_pkg::*;

  // Requests and responses between the sequencer and its shared parts.
  mem_req_t mem_req;
  count_t   mem_rdata;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // The sequencer owns all control state: the hand, the fill count, the
  // pending result and the output register that decouples the result
  // channel from the input side.
  ccr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_mode_i   (in_i.mode),
    .in_slot_i   (in_i.slot_index),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_slot_o  (out_o.chosen_slot),
    .out_free_o  (out_o.was_free),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp)
  );

  // The usage counters live in one memory. During a sweep the sequencer
  // writes back the decremented counter of the current slot while it
  // reads the counter of the next one.
  ccr_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // One counter unit serves both the saturating increment of a hit and
  // the decrement and zero test of the sweep.
  ccr_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for clock_counter_replacement: directed table, then random
// hit and request traffic scored against a behavioral model of the replacement policy.
// Depends on ccr_pkg and the channel interfaces in ccr_if.sv.
module tb;
  import ccr_pkg::*;

  // A request returns one grant; a hit returns nothing.
  typedef struct packed {
    logic [IDX_W-1:0] chosen_slot;
    logic             was_free;
  } grant_t;

  // One row of the directed table. When has_grant is set, the grant is typed in
  // here; otherwise the model decides what, if anything, comes back.
  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] slot;
    logic             has_grant;
    grant_t           grant;
  } plan_row_t;

  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int          RANDOM_ITEMS = 1840;
  localparam int          DRAIN_CYCLES = 50;
  localparam int          REPORT_MAX   = 10;

  // Slot 0 takes one hit in the table, then this many more in a row. The total is
  // one past the counter maximum, so a counter that wrapped instead of saturating
  // would sit at zero and be evicted by the very first sweep.
  localparam int SAT_BURST = (1 << COUNT_BITS) - 1;

  // Phase switch points within the random part, in items.
  localparam int PACE_SWITCH_1 = 613;
  localparam int PACE_SWITCH_2 = 1226;

  // Directed table. Right after reset the fill counter starts at zero, so the
  // first requests must get slots 0, 1, 2, ... from the never-used pool, whatever
  // slot_index says. Hits on slots not yet handed out (1023, the checkerboards)
  // still bump their counters.
  localparam plan_row_t PLAN [12] = '{
    '{MODE_REQ, 10'd0,    1'b1, '{10'd0, 1'b1}},
    '{MODE_REQ, 10'd1023, 1'b1, '{10'd1, 1'b1}},
    '{MODE_HIT, 10'd0,    1'b0, '{10'd0, 1'b0}},
    '{MODE_HIT, 10'd1023, 1'b0, '{10'd0, 1'b0}},
    '{MODE_HIT, 10'd1023, 1'b0, '{10'd0, 1'b0}},
    '{MODE_HIT, 10'h2AA,  1'b0, '{10'd0, 1'b0}},
    '{MODE_HIT, 10'h155,  1'b0, '{10'd0, 1'b0}},
    '{MODE_REQ, 10'h2AA,  1'b1, '{10'd2, 1'b1}},
    '{MODE_REQ, 10'h155,  1'b1, '{10'd3, 1'b1}},
    '{MODE_HIT, 10'd1,    1'b0, '{10'd0, 1'b0}},
    '{MODE_HIT, 10'd3,    1'b0, '{10'd0, 1'b0}},
    '{MODE_REQ, 10'd0,    1'b1, '{10'd4, 1'b1}}
  };

  logic clk_i;
  logic rst_ni;

  ccr_in_if  in_if ();
  ccr_out_if out_if ();

  clock_counter_replacement dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Period of 12 time units.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Model state: one usage counter per slot, the clock hand and the fill counter
  // that stands in for the external free list.
  count_t             use_count [SLOTS];
  slot_t              clock_hand;
  logic [FILL_BITS-1:0] filled;

  grant_t pending_grants [$];

  int src_idle_pct;
  int sink_stall_pct;
  int mismatch_count = 0;
  int unsigned cycle_count = 0;

  function automatic slot_t next_slot(input slot_t h);
    return (h == slot_t'(SLOTS - 1)) ? '0 : slot_t'(h + 1'b1);
  endfunction

  // Applies one transaction to the model. Returns 1 and the grant for a request,
  // 0 for a hit.
  function automatic bit predict_grant(input logic m, input logic [IDX_W-1:0] s,
                                       output grant_t g);
    g = '0;
    if (m == MODE_HIT) begin
      // Saturating increment; a slot beyond the table would be ignored.
      if (int'(s) < SLOTS && use_count[s] != {COUNT_BITS{1'b1}}) begin
        use_count[s] = use_count[s] + 1'b1;
      end
      return 1'b0;
    end
    if (int'(filled) < SLOTS) begin
      // Never-used slots go first, in index order; hand and counters stay put.
      g.chosen_slot = filled[IDX_W-1:0];
      g.was_free    = 1'b1;
      filled        = filled + 1'b1;
      return 1'b1;
    end
    // The sweep: every nonzero counter passed loses one, so this always ends.
    while (use_count[clock_hand] != '0) begin
      use_count[clock_hand] = use_count[clock_hand] - 1'b1;
      clock_hand = next_slot(clock_hand);
    end
    g.chosen_slot = IDX_W'(clock_hand);
    g.was_free    = 1'b0;
    clock_hand    = next_slot(clock_hand);
    return 1'b1;
  endfunction

  // Idle mix per phase: sender mostly busy and receiver stalling hard, then the other
  // way round, then both at full rate.
  function automatic void set_pace(input int phase);
    case (phase)
      0: begin
        src_idle_pct   = 32;
        sink_stall_pct = 87;
      end
      1: begin
        src_idle_pct   = 87;
        sink_stall_pct = 32;
      end
      default: begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
    endcase
  endfunction

  function automatic void log_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  // Presents one transaction, holds it until the block takes it, then runs the
  // model. Called at a rising edge. Valid is lowered only when a gap is inserted,
  // so it is never dropped and raised again in the same step.
  task automatic drive_item(input logic m, input logic [IDX_W-1:0] s,
                            input logic has_grant, input grant_t typed_grant);
    grant_t g;
    bit     makes_grant;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= m;
    in_if.slot_index <= s;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    makes_grant = predict_grant(m, s, g);
    // Directed rows with a typed-in grant are scored against that value.
    if (has_grant) begin
      pending_grants.push_back(typed_grant);
    end else if (makes_grant) begin
      pending_grants.push_back(g);
    end
  endtask

  // Lets every outstanding grant come back before traffic resumes.
  task automatic drain_grants();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_grants.size() != 0) @(posedge clk_i);
  endtask

  // The receiver stalls at random according to the current phase. Ready is
  // unknown only until the first edge, while reset holds the output idle.
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Scoreboard: each grant taken by the receiver is matched against the oldest
  // expectation. Signals are read before the edge's updates land.
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_grants.size() == 0) begin
        log_failure($sformatf("unexpected grant slot=%0d was_free=%0b",
                              out_if.chosen_slot, out_if.was_free));
      end else begin
        want = pending_grants.pop_front();
        if (out_if.chosen_slot !== want.chosen_slot) begin
          log_failure($sformatf("chosen_slot expected %0d, got %0d",
                                want.chosen_slot, out_if.chosen_slot));
        end
        if (out_if.was_free !== want.was_free) begin
          log_failure($sformatf("was_free for slot %0d expected %0b, got %0b",
                                want.chosen_slot, want.was_free, out_if.was_free));
        end
      end
    end
  end

  // Watchdog. The bound covers the clearing pass, all sweeps (their total length
  // cannot exceed hits plus requests) and the worst random gaps, with wide margin.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic             m;
    logic [IDX_W-1:0] s;
    int               pick;
    int               req_pct;

    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.mode       <= MODE_HIT;
    in_if.slot_index <= '0;
    foreach (use_count[i]) use_count[i] = '0;
    clock_hand = '0;
    filled     = '0;
    set_pace(0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block clears its counters after reset; the first handshake simply
    // waits for ready.
    foreach (PLAN[i]) begin
      drive_item(PLAN[i].mode, PLAN[i].slot, PLAN[i].has_grant, PLAN[i].grant);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // At each change of idle mix the sender also holds off until the output
      // side has gone completely quiet.
      if (n == PACE_SWITCH_1 || n == PACE_SWITCH_2) begin
        drain_grants();
        set_pace((n == PACE_SWITCH_1) ? 1 : 2);
      end
      pick = $urandom_range(99);
      if (n < SAT_BURST) begin
        // Saturation burst on slot 0, which the hand meets first once sweeping starts.
        m = MODE_HIT;
        s = '0;
      end else begin
        // Mostly requests until the never-used pool is gone, so the sweep gets a
        // long stretch of the run; after that an even mix.
        req_pct = (int'(filled) < SLOTS) ? 90 : 50;
        m = ($urandom_range(99) < req_pct) ? MODE_REQ : MODE_HIT;
        if (pick < 45) begin
          // Just ahead of the hand, so sweeps meet nonzero counters.
          s = IDX_W'((int'(clock_hand) + $urandom_range(0, 31)) % SLOTS);
        end else if (pick < 90) begin
          s = IDX_W'($urandom_range(0, SLOTS - 1));
        end else if (pick < 95) begin
          s = '0;
        end else begin
          s = IDX_W'(SLOTS - 1);
        end
      end
      drive_item(m, s, 1'b0, '0);
    end

    drain_grants();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_grants.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
